// ----- rtl/core/padx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padx_pkg
// Shared widths, reset values, state type and divider result bundle for the
// p-adic digit expander.
// ----------------------------------------------------------------------------
package padx_pkg;

    localparam int PADX_VALUE_W    = 32;
    localparam int PADX_DIGIT_W    = 8;
    localparam int PADX_POS_W      = 5;
    localparam int PADX_STEP_W     = $clog2(PADX_VALUE_W);
    localparam int PADX_MAX_DIGITS = 32;
    localparam int PADX_POS_LIMIT  = 1 << PADX_POS_W;

    localparam logic [PADX_DIGIT_W-1:0] PADX_RADIX_RESET = 8'd5;
    localparam logic [PADX_DIGIT_W-1:0] PADX_RADIX_MIN   = 8'd2;

    typedef enum logic
    {
        PADX_IDLE,
        PADX_RUN
    } padx_state_t;

    // Result of one division pass, valid while done is high.
    typedef struct packed
    {
        logic                    done;
        logic [PADX_VALUE_W-1:0] quotient;
        logic [PADX_DIGIT_W-1:0] remainder;
    } padx_div_res_t;

endpackage

// ----- rtl/core/padx_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padx_div
// Bit-serial restoring divider: divides a 32-bit magnitude by an 8-bit radix,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module padx_div
    import padx_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [PADX_VALUE_W-1:0] dividend,
    input  logic [PADX_DIGIT_W-1:0] divisor,
    output padx_div_res_t           res
);

    localparam logic [PADX_STEP_W-1:0] LAST_STEP = PADX_STEP_W'(PADX_VALUE_W - 1);

    logic [PADX_VALUE_W-1:0] quo_reg, quo_next;
    logic [PADX_DIGIT_W-1:0] rem_reg, rem_next;
    logic [PADX_STEP_W-1:0]  step_reg, step_next;
    logic                    run_reg, run_next;
    logic                    done_reg, done_next;

    logic [PADX_DIGIT_W:0]   trial;
    logic [PADX_DIGIT_W:0]   diff;
    logic                    fits;

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    assign trial = {rem_reg, quo_reg[PADX_VALUE_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            quo_next  = {quo_reg[PADX_VALUE_W-2:0], fits};
            rem_next  = fits ? diff[PADX_DIGIT_W-1:0] : trial[PADX_DIGIT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// ----- rtl/core/padic_digit_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padic_digit_expander
// Expands a signed 32-bit integer into base-p digits, least significant
// first, with p-adic negation for negative inputs.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. For each digit the
// bit-serial divider makes one quotient bit per cycle, over the full 32-bit
// magnitude every time, and the block then hands the next division its start.
// A request yields between one and 32 digits and keeps busy high throughout;
// the last digit appears on the outputs in the cycle that busy falls, and a
// new request may be taken in that same cycle. Every digit is shown for
// exactly one cycle with digit_valid high and cannot be held off, so the
// receiver must take it then. The radix is written through cfg_valid/cfg_ready
// (always ready) and must only change while the block is idle; values below
// two act as two.
// ----------------------------------------------------------------------------
module padic_digit_expander
    import padx_pkg::*;
#(
    parameter int MAX_DIGITS = PADX_MAX_DIGITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel
    input  logic                           start,
    output logic                           busy,
    input  logic signed [PADX_VALUE_W-1:0] value,
    // Radix register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [PADX_DIGIT_W-1:0]        radix,
    // Digit results
    output logic                           digit_valid,
    output logic [PADX_DIGIT_W-1:0]        digit,
    output logic [PADX_POS_W-1:0]          position,
    output logic                           last
);

    // A run never goes beyond MAX_DIGITS digits nor the width of position.
    localparam int LIMIT = (MAX_DIGITS < PADX_POS_LIMIT) ? MAX_DIGITS : PADX_POS_LIMIT;
    localparam logic [PADX_POS_W-1:0] LAST_POS = PADX_POS_W'(LIMIT - 1);

    padx_state_t state_reg, state_next;

    logic [PADX_DIGIT_W-1:0] radix_reg;
    logic [PADX_DIGIT_W-1:0] p_reg, p_next;
    logic                    neg_reg, neg_next;
    logic                    seen_reg, seen_next;
    logic [PADX_POS_W-1:0]   idx_reg, idx_next;

    logic                    valid_reg, valid_next;
    logic [PADX_DIGIT_W-1:0] digit_reg, digit_next;
    logic [PADX_POS_W-1:0]   pos_reg, pos_next;
    logic                    last_reg, last_next;

    logic                    div_start;
    logic [PADX_VALUE_W-1:0] div_dividend;
    padx_div_res_t           div_res;

    logic [PADX_VALUE_W-1:0] magnitude;
    logic [PADX_DIGIT_W-1:0] p_eff;
    logic [PADX_DIGIT_W-1:0] rem;
    logic                    rem_zero;
    logic                    is_last;
    logic [PADX_DIGIT_W-1:0] out_digit;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != PADX_IDLE);

    // The most negative input negates to 2^31, which still fits unsigned.
    assign magnitude = value[PADX_VALUE_W-1] ? (PADX_VALUE_W'(0) - PADX_VALUE_W'(value))
                                             : PADX_VALUE_W'(value);
    assign p_eff     = (radix_reg < PADX_RADIX_MIN) ? PADX_RADIX_MIN : radix_reg;

    assign rem      = div_res.remainder;
    assign rem_zero = (rem == '0);
    // The run ends once nothing is left to divide, or at the digit limit.
    assign is_last  = (div_res.quotient == '0) || (idx_reg == LAST_POS);

    // p-adic negation: low zero digits stay zero, the first nonzero digit d
    // becomes p-d and every digit above it becomes p-1-d.
    always_comb
    begin
        if (!neg_reg)
        begin
            out_digit = rem;
        end
        else if (seen_reg)
        begin
            out_digit = p_reg - 1'b1 - rem;
        end
        else if (!rem_zero)
        begin
            out_digit = p_reg - rem;
        end
        else
        begin
            out_digit = '0;
        end
    end

    padx_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (p_reg),
        .res      (div_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        neg_next     = neg_reg;
        seen_next    = seen_reg;
        idx_next     = idx_reg;
        valid_next   = 1'b0;
        digit_next   = digit_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        div_start    = 1'b0;
        div_dividend = div_res.quotient;
        case (state_reg)
            PADX_IDLE:
            begin
                if (start)
                begin
                    div_start    = 1'b1;
                    div_dividend = magnitude;
                    p_next       = p_eff;
                    neg_next     = value[PADX_VALUE_W-1];
                    seen_next    = 1'b0;
                    idx_next     = '0;
                    state_next   = PADX_RUN;
                end
            end
            PADX_RUN:
            begin
                if (div_res.done)
                begin
                    valid_next = 1'b1;
                    digit_next = out_digit;
                    pos_next   = idx_reg;
                    last_next  = is_last;
                    idx_next   = idx_reg + 1'b1;
                    if (!rem_zero)
                    begin
                        seen_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = PADX_IDLE;
                    end
                    else
                    begin
                        // The quotient just produced is divided again.
                        div_start = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = PADX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PADX_IDLE;
            radix_reg <= PADX_RADIX_RESET;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                radix_reg <= radix;
            end
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        digit_reg <= digit_next;
        pos_reg   <= pos_next;
        last_reg  <= last_next;
    end

    assign digit_valid = valid_reg;
    assign digit       = digit_reg;
    assign position    = pos_reg;
    assign last        = last_reg;

    // Every digit lies below the radix in use for the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (digit < p_reg))
    else $error("digit not below the radix");

    // The final digit leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (digit_valid && last) |-> (state_reg == PADX_IDLE))
    else $error("still busy on the last digit");

    // A division only finishes while a run is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == PADX_RUN))
    else $error("division finished outside a run");

    // Two digits of one run never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (digit_valid && !last) |=> !digit_valid)
    else $error("digits of one run too close together");

endmodule
